// ===== rtl/core/rbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbmc_pkg
// Shared types and constants for the red blob mask and centroid block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbmc_pkg;

  // field widths
  localparam int unsigned PixW = 8;
  localparam int unsigned ThrW = 8;
  localparam int unsigned ColW = 9;
  localparam int unsigned RowW = 8;
  localparam int unsigned CntW = 17;
  localparam int unsigned SumW = 25;

  // size limits and register reset values
  localparam int unsigned DefMaxWidth  = 320;
  localparam int unsigned DefMaxHeight = 240;
  localparam logic [ThrW-1:0] ThrReset    = 8'd40;
  localparam logic [ColW-1:0] WidthReset  = 9'd320;
  localparam logic [RowW-1:0] HeightReset = 8'd240;

  // mask values
  localparam logic [PixW-1:0] MaskRed   = 8'd0;
  localparam logic [PixW-1:0] MaskOther = 8'd255;

  // register map, word index of paddr
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegWidth     = 2'd1;
  localparam logic [1:0] RegHeight    = 2'd2;

  // result kinds
  localparam logic KindMask     = 1'b0;
  localparam logic KindCentroid = 1'b1;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] mask_value;
    logic [ColW-1:0] centroid_x;
    logic [RowW-1:0] centroid_y;
    logic [CntW-1:0] red_total;
    logic            found;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [ThrW-1:0] threshold;
    logic [ColW-1:0] width;
    logic [RowW-1:0] height;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_pix;
    logic div_start;
    logic load_cent;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic out_free;
    logic div_busy;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbmc_regs.sv =====
// ----------------------------------------------------------------------------
// rbmc_regs
// APB-style configuration registers: threshold, frame width, frame height.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbmc_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rbmc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output rbmc_pkg::cfg_t                  cfg_o
);
  import rbmc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegThreshold: cfg_d.threshold = pwdata[ThrW-1:0];
        RegWidth:     cfg_d.width     = pwdata[ColW-1:0];
        RegHeight:    cfg_d.height    = pwdata[RowW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThrReset;
      cfg_q.width     <= WidthReset;
      cfg_q.height    <= HeightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = 32'(cfg_q.threshold);
      RegWidth:     prdata = 32'(cfg_q.width);
      RegHeight:    prdata = 32'(cfg_q.height);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbmc_div.sv =====
// ----------------------------------------------------------------------------
// rbmc_div
// Restoring divider, one quotient bit per cycle, two dividends sharing one
// divisor (column sum and row sum over the red count).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbmc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rbmc_pkg::SumW-1:0] dividend_x_i,
  input  wire logic [rbmc_pkg::SumW-1:0] dividend_y_i,
  input  wire logic [rbmc_pkg::CntW-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [rbmc_pkg::SumW-1:0]      quot_x_o,
  output logic [rbmc_pkg::SumW-1:0]      quot_y_o
);
  import rbmc_pkg::*;

  localparam int unsigned StepW = $clog2(SumW);
  localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   dvs_q, dvs_d;
  logic [SumW-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [CntW-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic [CntW:0]     sx, sy;
  logic              gex, gey;

  // trial subtraction for both lanes
  assign sx  = {rx_q, qx_q[SumW-1]};
  assign sy  = {ry_q, qy_q[SumW-1]};
  assign gex = sx >= {1'b0, dvs_q};
  assign gey = sy >= {1'b0, dvs_q};

  assign done_o = busy_q && (step_q == LastStep);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvs_d  = dvs_q;
    qx_d   = qx_q;
    qy_d   = qy_q;
    rx_d   = rx_q;
    ry_d   = ry_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvs_d  = divisor_i;
      qx_d   = dividend_x_i;
      qy_d   = dividend_y_i;
      rx_d   = '0;
      ry_d   = '0;
    end else if (busy_q) begin
      // dividend bits shift out at the top, quotient bits shift in below
      qx_d   = {qx_q[SumW-2:0], gex};
      qy_d   = {qy_q[SumW-2:0], gey};
      rx_d   = gex ? CntW'(sx - {1'b0, dvs_q}) : sx[CntW-1:0];
      ry_d   = gey ? CntW'(sy - {1'b0, dvs_q}) : sy[CntW-1:0];
      step_d = StepW'(step_q + 1'b1);
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    qx_q  <= qx_d;
    qy_q  <= qy_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
  end

  assign busy_o   = busy_q;
  assign quot_x_o = qx_q;
  assign quot_y_o = qy_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbmc_ctrl
// Sequencer: streams pixels, waits for the centroid divide at frame end,
// then issues the centroid word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbmc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rbmc_pkg::stat_t stat_i,
  output rbmc_pkg::cmd_t       cmd_o
);
  import rbmc_pkg::*;

  typedef enum logic [1:0] {
    StRun,
    StDiv,
    StCent
  } ctrl_state_e;

  ctrl_state_e state_q;

  // commands from current state
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StRun: begin
        in_ready_o      = stat_i.out_free;
        cmd_o.load_pix  = in_valid_i && stat_i.out_free;
        cmd_o.div_start = in_valid_i && stat_i.out_free && stat_i.frame_end;
      end
      StDiv: begin
        in_ready_o = 1'b0;
      end
      StCent: begin
        cmd_o.load_cent = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
    end else begin
      unique case (state_q)
        StRun:   if (cmd_o.div_start) state_q <= StDiv;
        StDiv:   if (stat_i.div_done) state_q <= StCent;
        StCent:  if (cmd_o.load_cent) state_q <= StRun;
        default: state_q <= StRun;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rbmc_dp.sv =====
// ----------------------------------------------------------------------------
// rbmc_dp
// Datapath: color test, raster position, red accumulators, centroid divider
// and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbmc_dp #(
  parameter int unsigned MAX_WIDTH  = rbmc_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = rbmc_pkg::DefMaxHeight
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rbmc_pkg::cfg_t cfg_i,
  input  wire rbmc_pkg::pix_t in_data_i,
  input  wire rbmc_pkg::cmd_t cmd_i,
  output rbmc_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rbmc_pkg::res_t      out_data_o
);
  import rbmc_pkg::*;

  // size limits, bounded by what the size registers can hold
  localparam int unsigned ColMax = (1 << ColW) - 1;
  localparam int unsigned RowMax = (1 << RowW) - 1;
  localparam logic [ColW-1:0] WidthLim  = ColW'(MAX_WIDTH  > ColMax ? ColMax : MAX_WIDTH);
  localparam logic [RowW-1:0] HeightLim = RowW'(MAX_HEIGHT > RowMax ? RowMax : MAX_HEIGHT);

  logic [ColW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic            is_red;
  logic [PixW+1:0] diff_g, diff_b, thr_ext;
  logic [ColW:0]   col_inc;
  logic [RowW:0]   row_inc;
  logic            row_wrap, frame_end;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_nx;
  logic [SumW-1:0] sx_q, sx_d, sx_nx;
  logic [SumW-1:0] sy_q, sy_d, sy_nx;
  logic [CntW-1:0] total_q;

  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;
  logic            out_free;

  logic            div_busy, div_done;
  logic [SumW-1:0] qx, qy;
  logic            found;

  // clamp frame size
  always_comb begin
    if (cfg_i.width == '0)          w_eff = ColW'(1);
    else if (cfg_i.width > WidthLim) w_eff = WidthLim;
    else                             w_eff = cfg_i.width;
    if (cfg_i.height == '0)          h_eff = RowW'(1);
    else if (cfg_i.height > HeightLim) h_eff = HeightLim;
    else                             h_eff = cfg_i.height;
  end

  // signed color differences against the threshold
  assign diff_g  = {2'b00, in_data_i.red} - {2'b00, in_data_i.green};
  assign diff_b  = {2'b00, in_data_i.red} - {2'b00, in_data_i.blue};
  assign thr_ext = {2'b00, cfg_i.threshold};
  assign is_red  = ($signed(diff_g) > $signed(thr_ext)) &&
                   ($signed(diff_b) > $signed(thr_ext));

  // raster position
  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign row_wrap  = col_inc >= {1'b0, w_eff};
  assign frame_end = row_wrap && (row_inc >= {1'b0, h_eff});

  // accumulator next values, wrapping at their widths
  assign cnt_nx = is_red ? CntW'(cnt_q + 1'b1) : cnt_q;
  assign sx_nx  = is_red ? SumW'(sx_q + SumW'(col_q)) : sx_q;
  assign sy_nx  = is_red ? SumW'(sy_q + SumW'(row_q)) : sy_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    if (cmd_i.load_pix) begin
      col_d = row_wrap ? '0 : col_inc[ColW-1:0];
      if (row_wrap) begin
        row_d = frame_end ? '0 : row_inc[RowW-1:0];
      end
      if (frame_end) begin
        cnt_d = '0;
        sx_d  = '0;
        sy_d  = '0;
      end else begin
        cnt_d = cnt_nx;
        sx_d  = sx_nx;
        sy_d  = sy_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
    end
  end

  // frame count snapshot for the centroid word
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      total_q <= cnt_nx;
    end
  end

  rbmc_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cmd_i.div_start),
    .dividend_x_i (sx_nx),
    .dividend_y_i (sy_nx),
    .divisor_i    (cnt_nx),
    .busy_o       (div_busy),
    .done_o       (div_done),
    .quot_x_o     (qx),
    .quot_y_o     (qy)
  );

  assign found = total_q != '0;

  // output word register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.load_pix) begin
      out_valid_d      = 1'b1;
      out_d            = '0;
      out_d.kind       = KindMask;
      out_d.mask_value = is_red ? MaskRed : MaskOther;
      out_d.last       = !frame_end;
    end else if (cmd_i.load_cent) begin
      out_valid_d      = 1'b1;
      out_d            = '0;
      out_d.kind       = KindCentroid;
      out_d.centroid_x = found ? qx[ColW-1:0] : '0;
      out_d.centroid_y = found ? qy[RowW-1:0] : '0;
      out_d.red_total  = total_q;
      out_d.found      = found;
      out_d.last       = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.frame_end = frame_end;
  assign stat_o.out_free  = out_free;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;

endmodule

`default_nettype wire

// ===== rtl/core/red_blob_mask_centroid.sv =====
// ----------------------------------------------------------------------------
// red_blob_mask_centroid
// Red color threshold mask over a raster pixel stream, with a per-frame
// centroid of the red pixels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one word per pixel, and each gives a mask
// word (0 for red, 255 otherwise) in the next cycle through an output
// register, so inside a frame the block takes one pixel per clock while the
// result side is ready. The last pixel of a frame starts a shared restoring
// divider that produces one quotient bit per cycle for both the column and
// row sums; no pixel is taken during its 25 divide steps nor until the
// centroid word is loaded, which waits for the result side to be ready.
// Frame width, height and the color threshold sit in APB registers at byte
// addresses threshold 0x0, width 0x4, height 0x8; write them only while no
// frame is in progress.
`timescale 1ns / 1ps
`default_nettype none

module red_blob_mask_centroid #(
  parameter int unsigned MAX_WIDTH  = rbmc_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = rbmc_pkg::DefMaxHeight
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire rbmc_pkg::pix_t             in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rbmc_pkg::res_t                  out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rbmc_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rbmc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  rbmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbmc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // no pixel taken while the divider runs
  a_no_pix_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_busy |-> !in_ready_o)
    else $error("pixel accepted during centroid divide");

  // centroid word always closes the pixel's results
  a_cent_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KindCentroid) |-> out_data_o.last)
    else $error("centroid word without last");

  // empty frame gives zero centroid and count
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KindCentroid && !out_data_o.found) |->
    (out_data_o.centroid_x == '0 && out_data_o.centroid_y == '0 &&
     out_data_o.red_total == '0))
    else $error("empty frame with nonzero centroid");

  // a frame end starts the divider on the next cycle
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start at frame end");
`endif

endmodule

`default_nettype wire
